// ----- hw/rtl/rmsdb_pkg.sv -----
`default_nettype none

package rmsdb_pkg;

   // Block length is a power of two so the mean is a plain shift.
   localparam int BLOCK_LOG2 = 10;
   localparam int BLOCK_LEN  = 1 << BLOCK_LOG2;

   localparam int SAMPLE_W = 16;
   localparam int SQ_W     = 31;                 // square of a 16-bit sample, max 2^30
   localparam int POS_W    = BLOCK_LOG2;
   localparam int SUM_W    = SQ_W + BLOCK_LOG2;
   localparam int MEAN_W   = SUM_W - BLOCK_LOG2; // mean square, max 2^30
   localparam int LEVEL_W  = 11;
   localparam int BAR_W    = 5;
   localparam int COUNT_W  = 16;
   localparam int EXP_W    = 5;
   localparam int FRAC_W   = 16;
   localparam int CNT_W    = $clog2(FRAC_W);
   localparam int L2_W     = EXP_W + FRAC_W;

   localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(BLOCK_LEN - 1);
   localparam logic [LEVEL_W-1:0] THR_RESET = LEVEL_W'(1120);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // 160*log10(2) in Q16, rounded
   localparam int LOG_SCALE_W = 22;
   localparam logic [LOG_SCALE_W-1:0] LOG_SCALE_Q16 = LOG_SCALE_W'(3156528);
   localparam int SCALE_PW = L2_W + LOG_SCALE_W;

   // normalize: shift steps 16, 8, 4, 2, 1
   localparam int NORM_TOP = 16;
   localparam logic [CNT_W-1:0] NORM_LAST   = CNT_W'(4);
   localparam logic [CNT_W-1:0] SQUARE_LAST = CNT_W'(FRAC_W - 1);

   // whole dB / 3 as (q * 171) >> 9, exact for q up to 127
   localparam int BAR_Q_W    = LEVEL_W - 4;
   localparam int BAR_RECIP_W = 8;
   localparam logic [BAR_RECIP_W-1:0] BAR_RECIP = BAR_RECIP_W'(171);
   localparam int BAR_SHIFT  = 9;
   localparam int BAR_PW     = BAR_Q_W + BAR_RECIP_W;

   // highest level reachable with 16-bit samples
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(1444);
   localparam logic [BAR_W-1:0]   BAR_MAX   = BAR_W'(30);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_NORM   = 5'b00010,
      ST_SQUARE = 5'b00100,
      ST_SCALE  = 5'b01000,
      ST_DONE   = 5'b10000
   } log_state_type;

   // closed block handed from the accumulator
   typedef struct packed {
      logic              valid;
      logic              clear;   // a restart was seen since the last block closed
      logic [MEAN_W-1:0] mean;
   } block_type;

   // finished level from the log unit
   typedef struct packed {
      logic               valid;
      logic               clear;
      logic [LEVEL_W-1:0] level;
   } level_type;

endpackage

`default_nettype wire

// ----- hw/rtl/rmsdb_accum.sv -----
`default_nettype none

module rmsdb_accum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic signed [rmsdb_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                          restart,
   output      rmsdb_pkg::block_type          block
);
   import rmsdb_pkg::*;

   // input register
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       s1_restart_ff;

   // square register
   logic                       s2_valid_ff;
   logic [SQ_W-1:0]            s2_sq_ff, s2_sq_in;
   logic                       s2_restart_ff;

   // accumulator
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       clr_ff, clr_in;
   block_type                  block_ff, block_in;

   logic signed [2*SAMPLE_W-1:0] sq_full;
   logic [SUM_W-1:0]             sum_base, sum_next;
   logic [POS_W-1:0]             pos_base;

   assign s1_valid_in = take;
   assign sq_full     = s1_sample_ff * s1_sample_ff;
   assign s2_sq_in    = sq_full[SQ_W-1:0];

   always_comb begin
      sum_base = s2_restart_ff ? '0 : sum_ff;
      pos_base = s2_restart_ff ? '0 : pos_ff;
      sum_next = sum_base + SUM_W'(s2_sq_ff);
      sum_in   = sum_ff;
      pos_in   = pos_ff;
      clr_in   = clr_ff;
      block_in = '0;
      if (s2_valid_ff) begin
         if (pos_base == POS_LAST) begin
            sum_in         = '0;
            pos_in         = '0;
            clr_in         = 1'b0;
            block_in.valid = 1'b1;
            block_in.clear = clr_ff | s2_restart_ff;
            block_in.mean  = sum_next[SUM_W-1:BLOCK_LOG2];
         end else begin
            sum_in = sum_next;
            pos_in = pos_base + POS_W'(1);
            clr_in = clr_ff | s2_restart_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
         pos_ff      <= '0;
         clr_ff      <= 1'b0;
         block_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         sum_ff      <= sum_in;
         pos_ff      <= pos_in;
         clr_ff      <= clr_in;
         block_ff    <= block_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_sample_ff  <= sample;
         s1_restart_ff <= restart;
      end
      s2_sq_ff      <= s2_sq_in;
      s2_restart_ff <= s1_restart_ff;
   end

   assign block = block_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rmsdb_log.sv -----
`default_nettype none

module rmsdb_log (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        start_clear,
   input  wire logic [rmsdb_pkg::MEAN_W-1:0] start_mean,
   output      logic                        idle,
   output      rmsdb_pkg::level_type        result,
   input  wire logic                        ack
);
   import rmsdb_pkg::*;

   log_state_type        state_ff, state_in;
   logic [MEAN_W-1:0]    x_ff, x_in;
   logic [EXP_W-1:0]     sh_ff, sh_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 clear_ff, clear_in;

   logic [EXP_W-1:0]     norm_size;
   logic                 top_zero;
   logic [2*MEAN_W-1:0]  sq_prod;
   logic [MEAN_W:0]      sq_top;
   logic [EXP_W-1:0]     expo;
   logic [L2_W-1:0]      l2;
   logic [SCALE_PW-1:0]  scale_prod;

   assign norm_size  = EXP_W'(NORM_TOP >> cnt_ff);
   assign top_zero   = (x_ff >> (EXP_W'(MEAN_W) - norm_size)) == '0;
   assign sq_prod    = (2*MEAN_W)'(x_ff) * (2*MEAN_W)'(x_ff);
   assign sq_top     = sq_prod[2*MEAN_W-1 -: MEAN_W+1];   // (x*x) >> 30
   assign expo       = EXP_W'(MEAN_W - 1) - sh_ff;
   assign l2         = {expo, frac_ff};
   assign scale_prod = SCALE_PW'(l2) * SCALE_PW'(LOG_SCALE_Q16);

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      sh_in    = sh_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      level_in = level_ff;
      clear_in = clear_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               clear_in = start_clear;
               x_in     = start_mean;
               sh_in    = '0;
               cnt_in   = '0;
               if (start_mean == '0) begin
                  level_in = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (top_zero) begin
               x_in  = x_ff << norm_size;
               sh_in = sh_ff + norm_size;
            end
            if (cnt_ff == NORM_LAST) begin
               cnt_in   = '0;
               state_in = ST_SQUARE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SQUARE: begin
            frac_in = {frac_ff[FRAC_W-2:0], sq_top[MEAN_W]};
            x_in    = sq_top[MEAN_W] ? sq_top[MEAN_W:1] : sq_top[MEAN_W-1:0];
            if (cnt_ff == SQUARE_LAST) begin
               cnt_in   = '0;
               state_in = ST_SCALE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SCALE: begin
            level_in = scale_prod[32 +: LEVEL_W];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      sh_ff    <= sh_in;
      frac_ff  <= frac_in;
      cnt_ff   <= cnt_in;
      level_ff <= level_in;
      clear_ff <= clear_in;
   end

   assign idle         = (state_ff == ST_IDLE);
   assign result.valid = (state_ff == ST_DONE);
   assign result.clear = clear_ff;
   assign result.level = level_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/block_rms_db_level_meter.sv -----
`default_nettype none

// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_ready   req_sample (s16), req_restart
// rsp      out  rsp_valid/rsp_ready   rsp_level_db_q4, rsp_bar_height, rsp_loud,
//                                     rsp_peak_count, rsp_max_level_db_q4
// csr      in   csr_wr_en             csr_wr_data (loud threshold, 1/16 dB)
//
// One sample per ready cycle; the square-accumulate path is three registers deep.
// A closed block goes to an iterative log unit: a start state, then normalize, squaring
// and scale states, with one 31x31 squarer reused for every squaring step.
// req_ready drops only while a closed block waits for the busy log unit.
// Synchronous active-high reset; threshold resets to 70 dB (1120).
// rsp stall holds the log unit, which then backs up into req_ready.

module block_rms_db_level_meter (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic signed [rmsdb_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic                                   req_restart,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      logic [rmsdb_pkg::LEVEL_W-1:0]          rsp_level_db_q4,
   output      logic [rmsdb_pkg::BAR_W-1:0]            rsp_bar_height,
   output      logic                                   rsp_loud,
   output      logic [rmsdb_pkg::COUNT_W-1:0]          rsp_peak_count,
   output      logic [rmsdb_pkg::LEVEL_W-1:0]          rsp_max_level_db_q4,
   input  wire logic                                   csr_wr_en,
   input  wire logic [rmsdb_pkg::LEVEL_W-1:0]          csr_wr_data
);
   import rmsdb_pkg::*;

   logic [LEVEL_W-1:0]   thr_q_ff;

   block_type            block;
   block_type            pend_ff, pend_in;
   logic                 take;

   logic                 log_idle, log_start, log_ack;
   level_type            log_res;

   // result stage and running statistics
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff;
   logic [BAR_W-1:0]     rsp_bar_ff;
   logic                 rsp_loud_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [LEVEL_W-1:0]   rsp_max_ff;

   logic                 epi_ff, epi_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [LEVEL_W-1:0]   high_ff, high_in;

   logic                 epi_base;
   logic [COUNT_W-1:0]   count_base;
   logic [LEVEL_W-1:0]   high_base;
   logic                 loud;
   logic [BAR_PW-1:0]    bar_prod;
   logic [BAR_W-1:0]     bar;

   // Only one block can be in flight between accept and the pending slot,
   // since blocks close at least BLOCK_LEN transfers apart. A pending block
   // that starts the idle log unit this cycle does not stall the input.
   assign req_ready = ~pend_ff.valid | log_idle;
   assign take      = req_valid & req_ready;

   rmsdb_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .sample  (req_sample),
      .restart (req_restart),
      .block   (block)
   );

   assign log_start = pend_ff.valid & log_idle;

   always_comb begin
      pend_in = pend_ff;
      if (log_start) begin
         pend_in.valid = 1'b0;
      end
      if (block.valid) begin
         pend_in = block;
      end
   end

   rmsdb_log u_log (
      .clock       (clock),
      .reset       (reset),
      .start       (log_start),
      .start_clear (pend_ff.clear),
      .start_mean  (pend_ff.mean),
      .idle        (log_idle),
      .result      (log_res),
      .ack         (log_ack)
   );

   // restart is deferred to the next closed block: stats only show there
   assign log_ack    = log_res.valid & (~rsp_valid_ff | rsp_ready);
   assign epi_base   = log_res.clear ? 1'b0 : epi_ff;
   assign count_base = log_res.clear ? '0 : count_ff;
   assign high_base  = log_res.clear ? '0 : high_ff;
   assign loud       = log_res.level > thr_q_ff;
   assign bar_prod   = BAR_PW'(log_res.level[LEVEL_W-1:4]) * BAR_PW'(BAR_RECIP);
   assign bar        = bar_prod[BAR_SHIFT +: BAR_W];

   always_comb begin
      epi_in       = epi_ff;
      count_in     = count_ff;
      high_in      = high_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (log_ack) begin
         rsp_valid_in = 1'b1;
         epi_in       = loud;
         count_in     = count_base;
         if (loud && !epi_base && count_base != COUNT_MAX) begin
            count_in = count_base + COUNT_W'(1);
         end
         high_in = (log_res.level > high_base) ? log_res.level : high_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_q_ff     <= THR_RESET;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         epi_ff       <= 1'b0;
         count_ff     <= '0;
         high_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            thr_q_ff <= csr_wr_data;
         end
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         epi_ff       <= epi_in;
         count_ff     <= count_in;
         high_ff      <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (log_ack) begin
         rsp_level_ff <= log_res.level;
         rsp_bar_ff   <= bar;
         rsp_loud_ff  <= loud;
         rsp_count_ff <= count_in;
         rsp_max_ff   <= high_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_level_db_q4     = rsp_level_ff;
   assign rsp_bar_height      = rsp_bar_ff;
   assign rsp_loud            = rsp_loud_ff;
   assign rsp_peak_count      = rsp_count_ff;
   assign rsp_max_level_db_q4 = rsp_max_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rmsdb_checker.sv -----
`default_nettype none

module rmsdb_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic [rmsdb_pkg::LEVEL_W-1:0]          rsp_level_db_q4,
   input wire logic [rmsdb_pkg::BAR_W-1:0]            rsp_bar_height,
   input wire logic                                   rsp_loud,
   input wire logic [rmsdb_pkg::COUNT_W-1:0]          rsp_peak_count,
   input wire logic [rmsdb_pkg::LEVEL_W-1:0]          rsp_max_level_db_q4
);
   import rmsdb_pkg::*;

   logic [BAR_W+1:0]   bar_x3;
   logic [LEVEL_W-5:0] whole_db;

   assign bar_x3   = (BAR_W+2)'(rsp_bar_height) * (BAR_W+2)'(3);
   assign whole_db = rsp_level_db_q4[LEVEL_W-1:4];

   // stalled transfer holds its level, peak count and max level
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level_db_q4)
         && $stable(rsp_peak_count) && $stable(rsp_max_level_db_q4))
      else $error("rsp payload changed while stalled");

   a_max_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_max_level_db_q4 >= rsp_level_db_q4)
      else $error("max level below block level");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level_db_q4 <= LEVEL_MAX && rsp_bar_height <= BAR_MAX)
      else $error("level out of range");

   a_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (BAR_W+2)'(whole_db) >= bar_x3
         && (BAR_W+2)'(whole_db) < bar_x3 + (BAR_W+2)'(3))
      else $error("bar height does not match level");

   a_loud_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_loud |-> rsp_peak_count != '0)
      else $error("loud block with zero episode count");

endmodule

bind block_rms_db_level_meter rmsdb_checker u_rmsdb_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;

   // Level meter bench: audio samples go in on req, one meter reading per
   // closed block of samples comes back on rsp.  An in-bench tracker follows
   // every accepted sample and queues the reading it must produce; the rsp
   // monitor checks each returned reading against the oldest queued one.

   localparam int LW = rmsdb_pkg::LEVEL_W;
   localparam int BW = rmsdb_pkg::BAR_W;
   localparam int CW = rmsdb_pkg::COUNT_W;
   localparam int SAMPLES_PER_BLOCK = rmsdb_pkg::BLOCK_LEN;

   // 160*log10(2) in Q16: turns log2 (Q16) into 1/16 dB of power
   localparam longint unsigned Q4DB_PER_OCTAVE_Q16 = 64'd3156528;
   localparam logic [LW-1:0] THRESHOLD_AT_RESET = 11'd1120;
   localparam logic [CW-1:0] EPISODES_CEILING = '1;

   localparam logic signed [15:0] FULL_NEG = 16'sh8000;
   localparam logic signed [15:0] FULL_POS = 16'sh7FFF;

   localparam int SETTLE_CYCLES = 64;     // accumulate pipe + log unit, with margin
   localparam int HOLD_OFF_CYCLES = 4000; // long enough for three blocks to close
   localparam int STALL_LIMIT = 20000;    // cycles with no transfer at all

   typedef struct packed {
      logic [LW-1:0] level;
      logic [BW-1:0] bar;
      logic          loud;
      logic [CW-1:0] episodes;
      logic [LW-1:0] top_level;
   } meter_reading_type;

   typedef enum logic [1:0] {
      FILL_CONST,    // every sample = value
      FILL_IMPULSE,  // first sample = value, rest silent
      FILL_NOISE     // uniform noise, amplitude 2**value
   } fill_kind_type;

   // one directed row = one run of samples, usually a whole block
   typedef struct packed {
      logic              set_thr;
      logic [LW-1:0]     thr;
      logic              restart;
      logic [10:0]       len;
      fill_kind_type     fill;
      logic signed [15:0] value;
      logic              pinned;   // golden reading typed in below
      meter_reading_type golden;
   } block_row_type;

   typedef struct packed {
      logic              pinned;
      meter_reading_type reading;
   } pin_type;

   localparam meter_reading_type SILENT = '0;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [rmsdb_pkg::SAMPLE_W-1:0] req_sample;
   logic req_restart;
   logic rsp_valid;
   logic rsp_ready;
   logic [LW-1:0] rsp_level_db_q4;
   logic [BW-1:0] rsp_bar_height;
   logic rsp_loud;
   logic [CW-1:0] rsp_peak_count;
   logic [LW-1:0] rsp_max_level_db_q4;
   logic csr_wr_en;
   logic [LW-1:0] csr_wr_data;

   block_rms_db_level_meter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample          (req_sample),
      .req_restart         (req_restart),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_level_db_q4     (rsp_level_db_q4),
      .rsp_bar_height      (rsp_bar_height),
      .rsp_loud            (rsp_loud),
      .rsp_peak_count      (rsp_peak_count),
      .rsp_max_level_db_q4 (rsp_max_level_db_q4),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // Tracker state: a private copy of the meter
   logic [LW-1:0]   thr_q4;
   longint unsigned square_total;
   int unsigned     fill_pos;
   logic            in_episode;
   logic [CW-1:0]   episode_count;
   logic [LW-1:0]   loudest;

   meter_reading_type readings_due[$];  // readings owed by the DUT, oldest first
   pin_type           pins[$];          // golden overrides for directed blocks
   int                mismatch_count = 0;

   // sender / receiver shaping
   int burst_left = 0;
   bit no_gaps = 1'b0;
   bit hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // 10*log10(mean square) in 1/16 dB: normalize, 16 squaring steps for
   // the log2 fraction, then scale.  Mean of zero reads as 0 dB.
   function automatic logic [LW-1:0] level_q4_of(input longint unsigned msq);
      int unsigned     top;
      longint unsigned x;
      int unsigned     frac;
      longint unsigned l2;
      if (msq == 0) return '0;
      top = 0;
      while (top < 63 && (msq >> (top + 1)) != 0) top++;
      if (top > 30) top = 30;
      x = (msq << (30 - top)) & 64'h7FFF_FFFF;
      frac = 0;
      for (int b = 0; b < 16; b++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= 64'h8000_0000) begin
            frac = frac | 1;
            x = x >> 1;
         end
      end
      l2 = (64'(top) << 16) | 64'(frac);
      l2 = (l2 * Q4DB_PER_OCTAVE_Q16) >> 32;
      if (l2 > 2047) l2 = 2047;
      return l2[LW-1:0];
   endfunction

   function automatic logic signed [15:0] noise_sample(input int k);
      int v;
      v = int'($urandom_range(0, (2 << k) - 1)) - (1 << k);
      if (v > 32767) v = 32767;
      return v[15:0];
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Tracker and checker share one clocked block so the order inside a
   // cycle is fixed: returned reading first, then register write, then
   // the newly accepted sample.
   always @(posedge clock) begin : track
      meter_reading_type got;
      meter_reading_type want;
      meter_reading_type calc;
      pin_type           pin;
      int                sv;
      longint unsigned   mag;
      logic [LW-1:0]     lvl;
      logic              is_loud;
      if (reset) begin
         thr_q4 = THRESHOLD_AT_RESET;
         square_total = 0;
         fill_pos = 0;
         in_episode = 1'b0;
         episode_count = '0;
         loudest = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_level_db_q4, rsp_bar_height, rsp_loud, rsp_peak_count,
                    rsp_max_level_db_q4};
            if (readings_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: reading with none expected, expected nothing, actual %p",
                        $time, got);
            end else begin
               want = readings_due.pop_front();
               compare_field("level_db_q4", want.level, got.level);
               compare_field("bar_height", want.bar, got.bar);
               compare_field("loud", want.loud, got.loud);
               compare_field("peak_count", want.episodes, got.episodes);
               compare_field("max_level_db_q4", want.top_level, got.top_level);
            end
         end

         if (csr_wr_en) thr_q4 = csr_wr_data;

         if (req_valid && req_ready) begin
            // restart wipes the block and the episode history first
            if (req_restart) begin
               square_total = 0;
               fill_pos = 0;
               in_episode = 1'b0;
               episode_count = '0;
               loudest = '0;
            end
            sv = int'(req_sample);
            mag = longint'(sv < 0 ? -sv : sv);
            square_total += mag * mag;
            fill_pos++;
            if (fill_pos == SAMPLES_PER_BLOCK) begin
               lvl = level_q4_of(square_total / SAMPLES_PER_BLOCK);
               square_total = 0;
               fill_pos = 0;
               if (lvl > loudest) loudest = lvl;
               // strictly above; only the entry into a loud run counts
               is_loud = (lvl > thr_q4);
               if (is_loud) begin
                  if (!in_episode && episode_count != EPISODES_CEILING)
                     episode_count++;
                  in_episode = 1'b1;
               end else begin
                  in_episode = 1'b0;
               end
               calc = '{lvl, BW'((lvl >> 4) / 3), is_loud, episode_count, loudest};
               if (pins.size() != 0) begin
                  pin = pins.pop_front();
                  if (pin.pinned) calc = pin.reading;
               end
               readings_due.push_back(calc);
            end
         end
      end
   end

   // Watchdog: too long without any transfer on either channel.
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Receiver: stall pattern switches between modes every so often; a
   // requested hold-off keeps rsp_ready low for a long counted stretch.
   initial begin : receiver
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 3000);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 0);
               2: rsp_ready <= ($urandom_range(0, 7) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // One sample transfer; sender idles between random-length bursts unless no_gaps.
   task automatic send_item(input logic signed [15:0] s, input logic rs);
      int gap;
      if (!no_gaps && burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(300, 2500)
                                                 : $urandom_range(1, 40);
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_sample <= s;
      req_restart <= rs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_run(input logic rs, input int len, input fill_kind_type fill,
                           input int value);
      logic signed [15:0] s;
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_CONST:   s = value[15:0];
            FILL_IMPULSE: s = (i == 0) ? value[15:0] : 16'sd0;
            default:      s = noise_sample(value);
         endcase
         send_item(s, rs && (i == 0));
      end
   endtask

   // Threshold write: drain all readings, let the log unit go quiet, write.
   task automatic write_threshold(input logic [LW-1:0] value);
      req_valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      block_row_type plan[21];
      int            phase_thr[6];
      int            k;
      int            pick;
      int            value;
      fill_kind_type fill;
      logic          rs;

      // golden readings: level, bar, loud, peak_count, max level
      plan = '{
         // silence after restart, constant one (mean exactly one), lone 1
         '{0, 0, 1, 1024, FILL_CONST,   16'sd0,  1, SILENT},
         '{0, 0, 0, 1024, FILL_CONST,   16'sd1,  1, SILENT},
         '{0, 0, 0, 1024, FILL_IMPULSE, 16'sd1,  1, SILENT},
         // full scale: 1444, first loud episode
         '{0, 0, 0, 1024, FILL_CONST,   FULL_NEG, 1, '{1444, 30, 1, 1, 1444}},
         '{0, 0, 0, 1024, FILL_CONST,   FULL_POS, 0, SILENT},
         // quiet block ends the episode, next loud block starts a new one
         '{0, 0, 0, 1024, FILL_CONST,   16'sd0,  1, '{0, 0, 0, 1, 1444}},
         '{0, 0, 0, 1024, FILL_CONST,   FULL_NEG, 1, '{1444, 30, 1, 2, 1444}},
         '{0, 0, 0, 1024, FILL_NOISE,   16'sd15, 0, SILENT},
         '{0, 0, 0, 1024, FILL_IMPULSE, FULL_NEG, 0, SILENT},
         // partial block thrown away by a restart
         '{0, 0, 0, 500,  FILL_CONST,   FULL_NEG, 0, SILENT},
         '{0, 0, 1, 1024, FILL_CONST,   16'sd0,  1, SILENT},
         '{0, 0, 0, 1024, FILL_NOISE,   16'sd4,  0, SILENT},
         '{0, 0, 0, 1024, FILL_NOISE,   16'sd8,  0, SILENT},
         '{0, 0, 0, 1024, FILL_NOISE,   16'sd12, 0, SILENT},
         '{0, 0, 0, 300,  FILL_NOISE,   16'sd15, 0, SILENT},
         '{0, 0, 1, 1024, FILL_NOISE,   16'sd15, 0, SILENT},
         // level equal to threshold is not loud; one below it is
         '{1, 1444, 1, 1024, FILL_CONST, FULL_NEG, 1, '{1444, 30, 0, 0, 1444}},
         '{1, 1443, 0, 1024, FILL_CONST, FULL_NEG, 1, '{1444, 30, 1, 1, 1444}},
         // zero threshold: level 0 is not loud, anything above is
         '{1, 0, 1, 1024, FILL_CONST,   16'sd1,  1, SILENT},
         '{0, 0, 0, 1024, FILL_CONST,   16'sd2,  0, SILENT},
         // threshold past the top of the range never trips
         '{1, 2047, 0, 1024, FILL_NOISE, 16'sd15, 0, SILENT}
      };
      phase_thr = '{0, 2047, 1456, 700, 1000, 0};
      phase_thr[5] = $urandom_range(0, 1456);

      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_restart = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (plan[i]) begin
         if (plan[i].set_thr) write_threshold(plan[i].thr);
         if (plan[i].len == SAMPLES_PER_BLOCK)
            pins.push_back('{plan[i].pinned, plan[i].golden});
         send_run(plan[i].restart, plan[i].len, plan[i].fill, plan[i].value);
      end

      // random phases, one threshold each
      foreach (phase_thr[p]) begin
         write_threshold(LW'(phase_thr[p]));
         // one phase streams back to back into a long rsp hold-off so the
         // log unit backs up and req_ready has to drop
         if (p == 3) begin
            no_gaps = 1'b1;
            hold_request = 1'b1;
         end
         repeat (8) begin
            // bias toward loud amplitudes so episodes open and close
            k = ($urandom_range(0, 2) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 15);
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
               fill = FILL_NOISE;
               value = k;
            end else if (pick < 17) begin
               fill = FILL_CONST;
               case ($urandom_range(0, 3))
                  0: value = 0;
                  1: value = FULL_NEG;
                  2: value = FULL_POS;
                  default: value = $urandom_range(0, 65535);
               endcase
            end else begin
               fill = FILL_IMPULSE;
               value = $urandom_range(0, 65535);
            end
            rs = ($urandom_range(0, 7) == 0);
            // now and then a restart lands mid-block
            if ($urandom_range(0, 9) == 0) begin
               send_run(1'b0, $urandom_range(1, SAMPLES_PER_BLOCK - 1), FILL_NOISE, k);
               rs = 1'b1;
            end
            send_run(rs, SAMPLES_PER_BLOCK, fill, value);
         end
         no_gaps = 1'b0;
      end

      req_valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
